/* rtl/core/rau_pkg.sv */
// shared constants for the rational arithmetic unit
// operation, status and order codes, port field widths
// no dependencies
package rau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FIELD_W        = 32;
	localparam int DEN_W          = 31;
	localparam int S_TDATA_W      = 128;
	localparam int M_TDATA_W      = 72;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;
	localparam logic [1:0] ST_ZDEN = 2'd3;

	localparam logic [1:0] ORD_LT = 2'd0;
	localparam logic [1:0] ORD_EQ = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

endpackage

/* rtl/core/rau_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// shared by the gcd loop and the reduction divides
// depends on nothing
module rau_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dvd,
	input  logic [W-1:0] dvs,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    sh;
	logic [W:0]    diff;

	assign sh   = {rem_q, quo_q[W-1]};
	assign diff = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dvd;
			dvs_q <= dvs;
		end else if (busy_q) begin
			rem_q <= diff[W] ? sh[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

/* rtl/core/rational_arithmetic_unit.sv */
// rational arithmetic unit: add, sub, mul, div, compare of two fractions with gcd reduction
// error beats (zero denominator, divide by zero) are answered from idle; else a and b are
// reduced, then multiplied and combined; compare and overflow end there, else the result is
// reduced as well; every reduction runs euclid steps on the single shared bit-serial divider
// one item at a time: next beat taken once back in idle and the output register is free
// reset: arst_n asynchronous active low clears the sequencer and the output valid
module rational_arithmetic_unit #(
	parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rau_pkg::S_TDATA_W-1:0] s_tdata,  // a_num, a_den, b_num, b_den
	input  logic [2:0]                    s_tuser,  // mode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rau_pkg::M_TDATA_W-1:0] m_tdata,  // res_num, res_den, order, zero fill
	output logic [1:0]                    m_tuser   // status
);
	import rau_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * W + 2;
	localparam int SW = 2 * W + 3;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RLOAD = 3'd1;
	localparam logic [2:0] S_GCD   = 3'd2;
	localparam logic [2:0] S_GCDW  = 3'd3;
	localparam logic [2:0] S_QNW   = 3'd4;
	localparam logic [2:0] S_QDW   = 3'd5;
	localparam logic [2:0] S_MUL   = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	localparam logic [1:0] SEL_A = 2'd0;
	localparam logic [1:0] SEL_B = 2'd1;
	localparam logic [1:0] SEL_R = 2'd2;

	logic [2:0] state_q;
	logic [1:0] sel_q;
	logic [1:0] step_q;
	logic       m_tvalid_q;

	logic [2:0]          mode_q;
	logic signed [W:0]   an_q, ad_q, bn_q, bd_q, wn_q, wd_q;
	logic [W-1:0]        nmag_q, dmag_q, x_q, y_q, g_q;
	logic                neg_q;
	logic signed [PW-1:0] p0_q, p1_q, p2_q;
	logic [FIELD_W-1:0]  res_num_q;
	logic [DEN_W-1:0]    res_den_q;
	logic [1:0]          order_q, status_q;

	logic signed [W:0] an_in, ad_in, bn_in, bd_in;
	logic              accept;
	logic              out_set;

	assign an_in  = {s_tdata[W-1], s_tdata[W-1:0]};
	assign ad_in  = {s_tdata[FIELD_W+W-1], s_tdata[FIELD_W+W-1:FIELD_W]};
	assign bn_in  = {s_tdata[2*FIELD_W+W-1], s_tdata[2*FIELD_W+W-1:2*FIELD_W]};
	assign bd_in  = {s_tdata[3*FIELD_W+W-1], s_tdata[3*FIELD_W+W-1:3*FIELD_W]};
	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// operand pair for reduction
	logic signed [W:0] ln, ld, lnm, ldm;
	always_comb begin
		case (sel_q)
			SEL_A:   begin ln = an_q; ld = ad_q; end
			SEL_B:   begin ln = bn_q; ld = bd_q; end
			default: begin ln = wn_q; ld = wd_q; end
		endcase
		lnm = ln[W] ? -ln : ln;
		ldm = ld[W] ? -ld : ld;
	end

	// shared divider
	logic         div_start, div_done;
	logic [W-1:0] div_dvd, div_dvs, div_quo, div_rem;

	always_comb begin
		div_start = 1'b0;
		div_dvd   = x_q;
		div_dvs   = y_q;
		case (state_q)
			S_GCD: begin
				div_start = 1'b1;
				if (y_q == '0) begin
					div_dvd = nmag_q;
					div_dvs = x_q;
				end
			end
			S_QNW: begin
				div_start = div_done;
				div_dvd   = dmag_q;
				div_dvs   = g_q;
			end
			default: ;
		endcase
	end

	rau_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// shared multiplier
	logic signed [W:0]    ma, mb;
	logic signed [PW-1:0] prod;
	always_comb begin
		case (step_q)
			2'd0:    begin ma = an_q; mb = (mode_q == MODE_MUL) ? bn_q : bd_q; end
			2'd1:    begin ma = ad_q; mb = bn_q; end
			default: begin ma = ad_q; mb = bd_q; end
		endcase
		prod = ma * mb;
	end

	// final combine, compare and range check
	logic signed [SW-1:0] p0e, p1e, rn_w, rd_w;
	logic                 ovf, is_cmp;
	logic [1:0]           ord;
	logic signed [W:0]    nfin;
	always_comb begin
		p0e    = SW'(p0_q);
		p1e    = SW'(p1_q);
		is_cmp = mode_q[2];
		case (mode_q)
			MODE_ADD: begin rn_w = p0e + p1e; rd_w = SW'(p2_q); end
			MODE_SUB: begin rn_w = p0e - p1e; rd_w = SW'(p2_q); end
			MODE_MUL: begin rn_w = p0e; rd_w = SW'(p2_q); end
			default:  begin
				rn_w = p1e[SW-1] ? -p0e : p0e;
				rd_w = p1e[SW-1] ? -p1e : p1e;
			end
		endcase
		ovf = !((&rn_w[SW-1:W-1]) || !(|rn_w[SW-1:W-1])) || (|rd_w[SW-1:W-1]);
		if (p0_q < p1_q)       ord = ORD_LT;
		else if (p0_q == p1_q) ord = ORD_EQ;
		else                   ord = ORD_GT;
		nfin = neg_q ? -$signed({1'b0, nmag_q}) : $signed({1'b0, nmag_q});
	end

	// result ready for the output register
	always_comb begin
		out_set = 1'b0;
		case (state_q)
			S_IDLE: out_set = accept && (ad_in == '0 || bd_in == '0 ||
			                             (s_tuser == MODE_DIV && bn_in == '0));
			S_QDW:  out_set = div_done && (sel_q != SEL_A) && (sel_q != SEL_B);
			S_FIN:  out_set = is_cmp || ovf;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sel_q      <= SEL_A;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_set) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sel_q  <= SEL_A;
						step_q <= '0;
						if (!out_set) state_q <= S_RLOAD;
					end
				end
				S_RLOAD: state_q <= S_GCD;
				S_GCD:   state_q <= (y_q == '0) ? S_QNW : S_GCDW;
				S_GCDW:  if (div_done) state_q <= S_GCD;
				S_QNW:   if (div_done) state_q <= S_QDW;
				S_QDW: begin
					if (div_done) begin
						case (sel_q)
							SEL_A: begin sel_q <= SEL_B; state_q <= S_RLOAD; end
							SEL_B: state_q <= S_MUL;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2) state_q <= S_FIN;
				end
				default: begin
					if (is_cmp || ovf) begin
						state_q <= S_IDLE;
					end else begin
						sel_q   <= SEL_R;
						state_q <= S_RLOAD;
					end
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q    <= s_tuser;
					an_q      <= an_in;
					ad_q      <= ad_in;
					bn_q      <= bn_in;
					bd_q      <= bd_in;
					res_num_q <= '0;
					res_den_q <= '0;
					order_q   <= ORD_LT;
					if (ad_in == '0 || bd_in == '0) status_q <= ST_ZDEN;
					else if (s_tuser == MODE_DIV && bn_in == '0) status_q <= ST_DIV0;
					else status_q <= ST_OK;
				end
			end
			S_RLOAD: begin
				nmag_q <= lnm[W-1:0];
				dmag_q <= ldm[W-1:0];
				x_q    <= lnm[W-1:0];
				y_q    <= ldm[W-1:0];
				neg_q  <= ln[W] ^ ld[W];
			end
			S_GCD: if (y_q == '0) g_q <= x_q;
			S_GCDW: begin
				if (div_done) begin
					x_q <= y_q;
					y_q <= div_rem;
				end
			end
			S_QNW: if (div_done) nmag_q <= div_quo;
			S_QDW: begin
				if (div_done) begin
					case (sel_q)
						SEL_A: begin an_q <= nfin; ad_q <= {1'b0, div_quo}; end
						SEL_B: begin bn_q <= nfin; bd_q <= {1'b0, div_quo}; end
						default: begin
							res_num_q <= FIELD_W'(nfin);
							res_den_q <= DEN_W'(div_quo);
						end
					endcase
				end
			end
			S_MUL: begin
				case (step_q)
					2'd0:    p0_q <= prod;
					2'd1:    p1_q <= prod;
					default: p2_q <= prod;
				endcase
			end
			default: begin
				if (is_cmp) order_q <= ord;
				else if (ovf) status_q <= ST_OVF;
				else begin
					wn_q <= rn_w[W:0];
					wd_q <= rd_w[W:0];
				end
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - FIELD_W - DEN_W - 2){1'b0}}, order_q, res_den_q, res_num_q};
	assign m_tuser  = status_q;
endmodule

/* rtl/core/rau_checker.sv */
// port-level checks for the rational arithmetic unit, bound to the top level
// depends on rau_pkg and rational_arithmetic_unit
module rau_port_checks (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [71:0]  m_tdata,
	input logic [1:0]   m_tuser
);
	import rau_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("error beat carries nonzero result");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64:63] != ORD_LT |-> m_tdata[62:0] == '0)
		else $error("compare beat carries a fraction");

	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[62:32] == '0 |-> m_tdata[31:0] == '0)
		else $error("nonzero numerator with zero denominator");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[64:63] != 2'd3)
		else $error("bad order code");
endmodule

bind rational_arithmetic_unit rau_port_checks u_rau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
